// ----- design/clhm_pkg.sv -----
// shared types and constants of the callback load histogram monitor
package clhm_pkg;

    localparam int BUCKETS_DEF    = 32;
    localparam int COUNT_BITS_DEF = 32;
    localparam int COUNT_BITS_MAX = 64;

    localparam int RATE_W     = 19;
    localparam int WIDTH_W    = 16;
    localparam int FRAMES_W   = 16;
    localparam int DUR_W      = 24;
    localparam int PCT_W      = 17;
    localparam int LOAD_W     = 16;
    localparam int LOAD_FRAC  = 12;
    localparam int PROD_W     = DUR_W + RATE_W;
    localparam int NUM_W      = PROD_W + LOAD_FRAC;
    localparam int US_W       = 20;
    localparam int DEN_W      = FRAMES_W + US_W;
    localparam int ANS_W      = 24;
    localparam int BIDX_OUT_W = 8;
    localparam int TOTAL_W    = 32;
    localparam int QPROD_W    = 48;
    localparam int STEP_W     = 4;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 128;
    localparam int CFG_IDX_W   = 2;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 19'd48000;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd205;
    localparam logic [US_W-1:0]    US_PER_S    = 20'd1000000;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE  = 2'd0,
        REG_BUCKET_WIDTH = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_MUL,
        ST_SATCHK,
        ST_LDIV,
        ST_BSET,
        ST_BDIV,
        ST_RD,
        ST_WR,
        ST_QMUL_LO,
        ST_QMUL_HI,
        ST_QTGT,
        ST_QPRIME,
        ST_QWALK,
        ST_QANS,
        ST_OUT
    } state_t;

    localparam state_t ST_CLR = ST_INIT;

endpackage

// ----- design/clhm_ram.sv -----
// generic single-write, single-read ram with registered read data
module clhm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/callback_load_histogram_monitor.sv -----
// top level of the callback load histogram monitor
//
// Takes one request at a time on s_axis: tuser is the operation (record, percentile query,
// clear). A record computes the load duration*rate*4096/(frames*1e6), saturated to 16 bits,
// then its bucket, and counts it, by two 16-step passes through one shared restoring divider
// (load, then load/bucket_width) followed by a read-modify-write of the histogram ram; when
// the load is zero or saturates the first pass is skipped. A query walks the buckets, at most
// BUCKETS of them, through the single ram read port feeding the running sum; a percentile of
// one or more skips the target multiply states, and a query of an empty histogram, like an
// unused op, goes straight to the output state. A clear writes one ram entry per cycle over
// all BUCKETS entries. After reset the same clearing pass runs with s_axis_tready low;
// configuration writes are taken at any time. Items never overlap in the ram, so the
// read-modify-write needs no forwarding. Results sit in an output register, so the next
// request is taken while the previous result waits for m_axis_tready.
module callback_load_histogram_monitor
    import clhm_pkg::*;
#(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // frame_count [15:0], duration_us [39:16], percentile [56:40], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op [1:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // current_load [15:0], peak_load [31:16], min_frames [47:32], max_frames [63:48],
    // bucket_index [71:64], sample_total [103:72], percentile_load [127:104]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [RATE_W-1:0]      cfg_data
);

    localparam int BIDX_W = $clog2(BUCKETS);
    localparam logic [BIDX_W-1:0] LAST_BUCKET = BIDX_W'(BUCKETS - 1);

    state_t state_reg, state_next;

    logic [RATE_W-1:0]    rate_reg;
    logic [WIDTH_W-1:0]   width_reg;
    op_t                  op_reg;
    logic [FRAMES_W-1:0]  frames_reg;
    logic [DUR_W-1:0]     dur_reg;
    logic [PCT_W-1:0]     pct_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic                 zero_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     dsh_reg;
    logic [LOAD_W-1:0]    quo_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [LOAD_W-1:0]    load_reg;
    logic [BIDX_W-1:0]    bucket_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [FRAMES_W-1:0]  fmin_reg;
    logic [FRAMES_W-1:0]  fmax_reg;
    logic [LOAD_W-1:0]    peak_reg;
    logic [LOAD_W-1:0]    last_load_reg;
    logic [QPROD_W-1:0]   prod_lo_reg;
    logic [QPROD_W-1:0]   prod_hi_reg;
    logic [COUNT_BITS-1:0] target_reg;
    logic [COUNT_BITS-1:0] cum_reg;
    logic [BIDX_W-1:0]    idx_reg;
    logic [ANS_W-1:0]     answer_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tvalid_reg;
    // a clear request shares the reset sweep; this marks that a result follows it
    logic                 clr_pending_reg;

    logic                  in_accept;
    op_t                   in_op;
    logic [FRAMES_W-1:0]   in_frames;
    logic [DUR_W-1:0]      in_dur;
    logic [PCT_W-1:0]      in_pct;
    logic                  out_free;
    logic [WIDTH_W-1:0]    weff;
    logic [PROD_W-1:0]     rate_prod;
    logic [DEN_W-1:0]      den_prod;
    logic                  load_sat;
    logic                  div_ge;
    logic [NUM_W-1:0]      div_sub;
    logic [BIDX_W-1:0]     bucket_cap;
    logic [COUNT_BITS_MAX-1:0] total_ext;
    logic [TOTAL_W-1:0]    total_out;
    logic [COUNT_BITS-1:0] total_inc;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS:0]   cum_sum;
    logic [COUNT_BITS-1:0] cum_new;
    logic                  walk_hit;
    logic [QPROD_W:0]      lo_round;
    logic [COUNT_BITS_MAX-1:0] target_sum;
    logic [BIDX_W-1:0]     idx_step;

    logic                  ram_we;
    logic [BIDX_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [BIDX_W-1:0]     ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    clhm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BUCKETS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_op     = op_t'(s_axis_tuser);
    assign in_frames = s_axis_tdata[FRAMES_W-1:0];
    assign in_dur    = s_axis_tdata[FRAMES_W+DUR_W-1:FRAMES_W];
    assign in_pct    = s_axis_tdata[FRAMES_W+DUR_W+PCT_W-1:FRAMES_W+DUR_W];
    assign out_free  = !m_tvalid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    // zero width behaves as width one
    assign weff = (width_reg == '0) ? WIDTH_W'(1) : width_reg;

    assign rate_prod = PROD_W'(dur_reg) * PROD_W'(rate_reg);
    assign den_prod  = DEN_W'(frames_reg) * DEN_W'(US_PER_S);
    assign load_sat  = num_reg >= NUM_W'({den_reg, 16'b0});

    // one restoring step of the shared divider
    assign div_ge  = rem_reg >= dsh_reg;
    assign div_sub = rem_reg - dsh_reg;

    assign bucket_cap = (quo_reg > LOAD_W'(BUCKETS - 1)) ? LAST_BUCKET
                                                         : quo_reg[BIDX_W-1:0];

    assign total_ext = COUNT_BITS_MAX'(total_reg);
    assign total_out = (|total_ext[COUNT_BITS_MAX-1:TOTAL_W]) ? '1 : total_ext[TOTAL_W-1:0];
    assign total_inc = (&total_reg) ? total_reg : total_reg + COUNT_BITS'(1);
    assign cnt_inc   = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

    assign cum_sum  = {1'b0, cum_reg} + {1'b0, ram_rdata};
    assign cum_new  = cum_sum[COUNT_BITS] ? '1 : cum_sum[COUNT_BITS-1:0];
    assign walk_hit = cum_new >= target_reg;
    assign idx_step = (idx_reg == LAST_BUCKET) ? '0 : idx_reg + BIDX_W'(1);

    // target = ceil(p * total / 2^16), from two 16x32 partial products
    assign lo_round   = {1'b0, prod_lo_reg} + (QPROD_W+1)'(16'hFFFF);
    assign target_sum = {prod_hi_reg, 16'b0}
                      + COUNT_BITS_MAX'(lo_round[QPROD_W:16]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (idx_reg == LAST_BUCKET)
                begin
                    state_next = clr_pending_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_op)
                        OP_RECORD: state_next = ST_MUL;
                        OP_QUERY:
                        begin
                            if (total_reg == '0)
                            begin
                                state_next = ST_OUT;
                            end
                            else if (in_pct[PCT_W-1])
                            begin
                                state_next = ST_QPRIME;
                            end
                            else
                            begin
                                state_next = ST_QMUL_LO;
                            end
                        end
                        OP_CLEAR:  state_next = ST_CLR;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_MUL:     state_next = ST_SATCHK;
            ST_SATCHK:  state_next = (zero_reg || load_sat) ? ST_BSET : ST_LDIV;
            ST_LDIV:    state_next = (step_reg == '0) ? ST_BSET : ST_LDIV;
            ST_BSET:    state_next = ST_BDIV;
            ST_BDIV:    state_next = (step_reg == '0) ? ST_RD : ST_BDIV;
            ST_RD:      state_next = ST_WR;
            ST_WR:      state_next = ST_OUT;
            ST_QMUL_LO: state_next = ST_QMUL_HI;
            ST_QMUL_HI: state_next = ST_QTGT;
            ST_QTGT:    state_next = ST_QPRIME;
            ST_QPRIME:  state_next = ST_QWALK;
            ST_QWALK:
            begin
                if (walk_hit || idx_reg == LAST_BUCKET)
                begin
                    state_next = ST_QANS;
                end
            end
            ST_QANS:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ram port control and handshake outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = '0;
        ram_raddr     = idx_reg;
        case (state_reg)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_INIT:   ram_we = 1'b1;
            ST_RD:     ram_raddr = bucket_cap;
            ST_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = bucket_reg;
                ram_wdata = cnt_inc;
            end
            ST_QPRIME: ram_raddr = '0;
            ST_QWALK:  ram_raddr = (idx_reg == LAST_BUCKET) ? idx_reg : idx_step;
            default:   ram_raddr = idx_reg;
        endcase
    end

    // control state, configuration and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            idx_reg         <= '0;
            clr_pending_reg <= 1'b0;
            rate_reg        <= RATE_RESET;
            width_reg       <= WIDTH_RESET;
            total_reg       <= '0;
            fmin_reg        <= '0;
            fmax_reg        <= '0;
            peak_reg        <= '0;
            last_load_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SAMPLE_RATE:  rate_reg <= cfg_data;
                    REG_BUCKET_WIDTH: width_reg <= cfg_data[WIDTH_W-1:0];
                    default:          ;
                endcase
            end

            case (state_reg)
                ST_INIT:
                begin
                    idx_reg       <= idx_step;
                    total_reg     <= '0;
                    fmin_reg      <= '0;
                    fmax_reg      <= '0;
                    peak_reg      <= '0;
                    last_load_reg <= '0;
                end
                ST_IDLE:
                begin
                    idx_reg         <= '0;
                    clr_pending_reg <= in_accept && in_op == OP_CLEAR;
                end
                ST_WR:
                begin
                    if (fmin_reg == '0 || frames_reg < fmin_reg)
                    begin
                        fmin_reg <= frames_reg;
                    end
                    if (frames_reg > fmax_reg)
                    begin
                        fmax_reg <= frames_reg;
                    end
                    if (load_reg > peak_reg)
                    begin
                        peak_reg <= load_reg;
                    end
                    last_load_reg <= load_reg;
                    total_reg     <= total_inc;
                end
                ST_QPRIME: idx_reg <= '0;
                ST_QWALK:
                begin
                    if (!walk_hit && idx_reg != LAST_BUCKET)
                    begin
                        idx_reg <= idx_step;
                    end
                end
                ST_OUT:    clr_pending_reg <= 1'b0;
                default:   ;
            endcase

            if (state_reg == ST_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_reg     <= in_op;
                    frames_reg <= in_frames;
                    dur_reg    <= in_dur;
                    pct_reg    <= in_pct;
                    answer_reg <= '0;
                    target_reg <= total_reg;
                    cum_reg    <= '0;
                end
            end
            ST_MUL:
            begin
                num_reg  <= {rate_prod, LOAD_FRAC'(0)};
                den_reg  <= den_prod;
                zero_reg <= (rate_reg == '0) || (frames_reg == '0);
            end
            ST_SATCHK:
            begin
                rem_reg  <= num_reg;
                dsh_reg  <= NUM_W'({den_reg, 15'b0});
                step_reg <= STEP_W'(LOAD_W - 1);
                if (zero_reg)
                begin
                    quo_reg <= '0;
                end
                else if (load_sat)
                begin
                    quo_reg <= '1;
                end
                else
                begin
                    quo_reg <= '0;
                end
            end
            ST_LDIV, ST_BDIV:
            begin
                if (div_ge)
                begin
                    rem_reg <= div_sub;
                end
                quo_reg  <= {quo_reg[LOAD_W-2:0], div_ge};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
            end
            ST_BSET:
            begin
                load_reg <= quo_reg;
                rem_reg  <= NUM_W'(quo_reg);
                dsh_reg  <= NUM_W'({weff, 15'b0});
                quo_reg  <= '0;
                step_reg <= STEP_W'(LOAD_W - 1);
            end
            ST_RD:      bucket_reg <= bucket_cap;
            ST_QMUL_LO:
            begin
                prod_lo_reg <= QPROD_W'(pct_reg[15:0]) * QPROD_W'(total_ext[31:0]);
            end
            ST_QMUL_HI:
            begin
                prod_hi_reg <= QPROD_W'(pct_reg[15:0])
                             * QPROD_W'(total_ext[COUNT_BITS_MAX-1:32]);
            end
            ST_QTGT:    target_reg <= COUNT_BITS'(target_sum);
            ST_QWALK:   cum_reg <= cum_new;
            ST_QANS:    answer_reg <= ANS_W'(idx_reg) * ANS_W'(weff);
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {answer_reg,
                                    total_out,
                                    (op_reg == OP_RECORD) ? BIDX_OUT_W'(bucket_reg)
                                                          : BIDX_OUT_W'(0),
                                    fmax_reg,
                                    fmin_reg,
                                    peak_reg,
                                    last_load_reg};
                end
            end
            default:    ;
        endcase
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // the peak never falls below the last load
    a_peak_covers_last: assert property (@(posedge clk) disable iff (!rst_n)
        last_load_reg <= peak_reg)
        else $error("peak load below last load");

    // a set minimum frame count never exceeds the maximum
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        fmin_reg <= fmax_reg)
        else $error("min frames above max frames");

    // the histogram update always lands inside the ram
    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR |-> bucket_reg <= LAST_BUCKET)
        else $error("bucket index out of range");

    // a result appears only after the output state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result without finished request");

endmodule

// ----- test/callback_load_histogram_monitor_tb.sv -----
// testbench of the load histogram monitor: predicted statistics checked against every result
module callback_load_histogram_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import clhm_pkg::*;

    localparam logic [1:0]           OP_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [16:0]          PCT_ONE     = 17'd65536;

    localparam int QUIET_LIMIT       = 2000;
    localparam int TAIL_CYCLES       = 80;
    localparam int SEGMENTS          = 12;
    localparam int ITEMS_PER_SEGMENT = 140;

    localparam int RATE_SET  [SEGMENTS] = '{48000, 384000, 0, 44100, 1, 96000,
                                            8000, 192000, 22050, 176400, 16000, 32000};
    localparam int WIDTH_SET [SEGMENTS] = '{205, 1, 300, 0, 128, 65535,
                                            4096, 512, 2048, 64, 1000, 3};

    typedef struct packed {
        logic [23:0] pct_load;
        logic [31:0] total;
        logic [7:0]  bucket;
        logic [15:0] frames_max;
        logic [15:0] frames_min;
        logic [15:0] peak;
        logic [15:0] load;
    } monitor_result_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [RATE_W-1:0]      cfg_data      = '0;

    // predictor copy of the registers and statistics
    logic [RATE_W-1:0]         cur_rate  = RATE_RESET;
    logic [WIDTH_W-1:0]        cur_width = WIDTH_RESET;
    logic [COUNT_BITS_DEF-1:0] bin_count [BUCKETS_DEF];
    logic [COUNT_BITS_DEF-1:0] sample_count;
    logic [15:0]               frames_lo, frames_hi, load_peak, load_last;

    monitor_result_t expected_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int results_checked = 0;
    int n_records = 0, n_queries = 0, n_clears = 0, n_spare = 0, n_settings = 0;

    callback_load_histogram_monitor DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_statistics();
        foreach (bin_count[i])
            bin_count[i] = '0;
        sample_count = '0;
        frames_lo    = '0;
        frames_hi    = '0;
        load_peak    = '0;
        load_last    = '0;
    endfunction

    function automatic logic [COUNT_BITS_DEF-1:0] sat_inc(logic [COUNT_BITS_DEF-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // statistics after one request, and the result it produces
    function automatic monitor_result_t predict_monitor(logic [1:0] op, logic [15:0] frames,
                                                        logic [23:0] dur, logic [16:0] pct);
        monitor_result_t r;
        logic [63:0]     quot, cum, target, p;
        logic [15:0]     load, w;
        int              bkt;
        bit              found;
        r = '0;
        w = (cur_width == '0) ? 16'd1 : cur_width;
        case (op)
            OP_RECORD:
            begin
                n_records++;
                if (frames_lo == '0 || frames < frames_lo)
                    frames_lo = frames;
                if (frames > frames_hi)
                    frames_hi = frames;
                if (cur_rate == '0 || frames == '0)
                    load = '0;
                else
                begin
                    quot = ((64'(dur) * 64'(cur_rate)) << LOAD_FRAC)
                           / (64'(frames) * 64'(US_PER_S));
                    load = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
                end
                load_last = load;
                if (load > load_peak)
                    load_peak = load;
                bkt = int'(load / w);
                if (bkt > BUCKETS_DEF - 1)
                    bkt = BUCKETS_DEF - 1;
                r.bucket       = 8'(bkt);
                bin_count[bkt] = sat_inc(bin_count[bkt]);
                sample_count   = sat_inc(sample_count);
            end
            OP_QUERY:
            begin
                n_queries++;
                if (sample_count != '0)
                begin
                    p = (pct > PCT_ONE) ? 64'(PCT_ONE) : 64'(pct);
                    // ceil(p * total / 2^16) split so the product never overflows
                    target = p * (64'(sample_count) >> 16)
                             + ((p * 64'(sample_count[15:0]) + 64'd65535) >> 16);
                    cum   = '0;
                    found = 1'b0;
                    r.pct_load = 24'((BUCKETS_DEF - 1) * w);
                    for (int i = 0; i < BUCKETS_DEF && !found; i++)
                    begin
                        cum += 64'(bin_count[i]);
                        if (cum >= target)
                        begin
                            r.pct_load = 24'(i * w);
                            found = 1'b1;
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                n_clears++;
                clear_statistics();
            end
            default: n_spare++;
        endcase
        r.load       = load_last;
        r.peak       = load_peak;
        r.frames_min = frames_lo;
        r.frames_max = frames_hi;
        r.total      = sample_count;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // result side: check each accepted result, then pick the next ready level
    always @(posedge clk)
    begin
        monitor_result_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result with nothing expected: %h", m_axis_tdata));
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                check_field("current_load", 32'(got.load), 32'(want.load));
                check_field("peak_load", 32'(got.peak), 32'(want.peak));
                check_field("min_frames", 32'(got.frames_min), 32'(want.frames_min));
                check_field("max_frames", 32'(got.frames_max), 32'(want.frames_max));
                check_field("bucket_index", 32'(got.bucket), 32'(want.bucket));
                check_field("sample_total", got.total, want.total);
                check_field("percentile_load", 32'(got.pct_load), 32'(want.pct_load));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic set_idle_mode(int mode);
        case (mode)
            0:       begin send_idle_pct = 37; recv_stall_pct = 70; end
            1:       begin send_idle_pct = 70; recv_stall_pct = 37; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // valid stays high after a request so back-to-back requests need no second drive
    task automatic send_request(logic [1:0] op, logic [15:0] frames, logic [23:0] dur,
                                logic [16:0] pct);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, pct, dur, frames};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(predict_monitor(op, frames, dur, pct));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SAMPLE_RATE:  cur_rate  = data;
            REG_BUCKET_WIDTH: cur_width = data[WIDTH_W-1:0];
            default: ;
        endcase
    endtask

    // bits above the width field are junk that the block must drop
    task automatic configure(int rate, int width);
        n_settings++;
        write_reg(REG_SAMPLE_RATE, RATE_W'(rate));
        write_reg(REG_BUCKET_WIDTH, {3'($urandom_range(7)), WIDTH_W'(width)});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_request(OP_QUERY, 16'd0, 24'd0, 17'd32768);
        send_request(OP_RECORD, 16'd256, 24'd5333, 17'd0);
        send_request(OP_RECORD, 16'd0, 24'd1000, 17'd0);
        send_request(OP_RECORD, 16'hFFFF, 24'hFFFFFF, 17'd0);
        send_request(OP_RECORD, 16'd1, 24'hFFFFFF, 17'd0);
        send_request(OP_RECORD, 16'd1, 24'd0, 17'd0);
        send_request(OP_QUERY, 16'd0, 24'd0, 17'd0);
        send_request(OP_QUERY, 16'd0, 24'd0, PCT_ONE);
        send_request(OP_QUERY, 16'hFFFF, 24'hFFFFFF, 17'h1FFFF);
        send_request(OP_QUERY, 16'd0, 24'd0, 17'd1);
        send_request(OP_QUERY, 16'd0, 24'd0, 17'd32768);
        wait_drain();
    endtask

    task automatic test_clear_and_spare();
        send_request(OP_SPARE, 16'hFFFF, 24'hFFFFFF, 17'h1FFFF);
        send_request(OP_CLEAR, 16'hFFFF, 24'hFFFFFF, 17'h1FFFF);
        send_request(OP_QUERY, 16'd0, 24'd0, PCT_ONE);
        send_request(OP_RECORD, 16'd128, 24'd2666, 17'd0);
        wait_drain();
    endtask

    task automatic test_register_extremes();
        // writes to unused indexes must leave both registers alone
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        configure(0, 0);
        send_request(OP_RECORD, 16'd100, 24'd5000, 17'd0);
        send_request(OP_QUERY, 16'd0, 24'd0, PCT_ONE);
        wait_drain();
        configure(384000, 0);
        send_request(OP_RECORD, 16'd1, 24'hFFFFFF, 17'd0);
        send_request(OP_RECORD, 16'd4096, 24'd20, 17'd0);
        send_request(OP_QUERY, 16'd0, 24'd0, PCT_ONE);
        wait_drain();
        configure(384000, 65535);
        send_request(OP_RECORD, 16'd1, 24'hFFFFFF, 17'd0);
        send_request(OP_QUERY, 16'd0, 24'd0, PCT_ONE);
        wait_drain();
        configure(1, 1);
        send_request(OP_RECORD, 16'd1, 24'hFFFFFF, 17'd0);
        wait_drain();
    endtask

    task automatic send_random_item();
        int          pick;
        logic [15:0] frames;
        logic [23:0] dur;
        logic [63:0] span;
        pick   = $urandom_range(99);
        frames = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(16, 2048));
        if (pick < 58)
        begin
            // duration around the frame period so loads spread over the buckets
            if (cur_rate == '0)
                dur = 24'($urandom_range(0, 50000));
            else
            begin
                span = 64'(frames) * 64'(US_PER_S) / 64'(cur_rate)
                       * $urandom_range(0, 320) / 100;
                dur  = (span > 64'hFFFFFF) ? 24'hFFFFFF : span[23:0];
            end
            send_request(OP_RECORD, frames, dur, 17'($urandom));
        end
        else if (pick < 70)
            send_request(OP_RECORD, 16'($urandom), 24'($urandom), 17'($urandom));
        else if (pick < 93)
            send_request(OP_QUERY, 16'($urandom), 24'($urandom),
                         (pick < 89) ? 17'($urandom_range(0, 65536)) : 17'($urandom));
        else if (pick < 95)
            send_request(OP_CLEAR, 16'($urandom), 24'($urandom), 17'($urandom));
        else
            send_request(OP_SPARE, 16'($urandom), 24'($urandom), 17'($urandom));
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            set_idle_mode(seg / 4);
            configure(RATE_SET[seg], WIDTH_SET[seg]);
            repeat (ITEMS_PER_SEGMENT)
                send_random_item();
            wait_drain();
        end
    endtask

    initial
    begin
        clear_statistics();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        set_idle_mode(0);
        test_reset_defaults();
        test_clear_and_spare();
        test_register_extremes();
        test_random_traffic();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        $display("covered %0d records, %0d queries, %0d clears, %0d unused ops, %0d settings",
                 n_records, n_queries, n_clears, n_spare, n_settings);
        $display("%0d results compared, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
